// ----- hw/rtl/scr_pkg.sv -----
package scr_pkg;

  localparam int POS_W   = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int MASS_W  = 31;
  localparam int ELAS_W  = 17;
  localparam int DIFF_W  = POS_W + 1;
  localparam int RAD_W   = 2 * DIFF_W;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int NFRAC_W = 30;
  localparam int NQ_W    = NFRAC_W + 1;
  localparam int NNUM_W  = DIFF_W + NFRAC_W;
  localparam int MSUM_W  = MASS_W + 1;
  localparam int WQ_W    = 17;
  localparam int WNUM_W  = MASS_W + 16;
  localparam int U_W     = 38;
  localparam int SAT_W   = 40;

  localparam logic [IDX_W-1:0] REG_SELF_MASS    = 3'd0;
  localparam logic [IDX_W-1:0] REG_OTHER_MASS   = 3'd1;
  localparam logic [IDX_W-1:0] REG_SELF_RADIUS  = 3'd2;
  localparam logic [IDX_W-1:0] REG_OTHER_RADIUS = 3'd3;
  localparam logic [IDX_W-1:0] REG_ELASTICITY   = 3'd4;

  localparam logic [MASS_W-1:0] RST_MASS   = 31'd65536;
  localparam logic [MASS_W-1:0] RST_RADIUS = 31'd65536;
  localparam logic [ELAS_W-1:0] RST_ELAS   = 17'd65536;

  typedef logic [2:0][POS_W-1:0] vec3_t;

  function automatic logic [POS_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v[SAT_W-1:POS_W-1] == '0 || v[SAT_W-1:POS_W-1] == '1) begin
      r = v[POS_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/scr_dly.sv -----
module scr_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [D];

  always_ff @(posedge clk) begin
    sr_r[0] <= d;
    for (int i = 1; i < D; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[D-1];

endmodule

// ----- hw/rtl/scr_sqrt.sv -----
module scr_sqrt import scr_pkg::*; #(
  parameter int RW = RAD_W
) (
  input  logic            clk,
  input  logic [RW-1:0]   rad,
  output logic [RW/2-1:0] root
);

  localparam int OW = RW / 2;
  localparam int MW = OW + 2;

  logic [RW-1:0] rad_r  [OW];
  logic [MW-1:0] rem_r  [OW];
  logic [OW-1:0] root_r [OW];

  for (genvar j = 0; j < OW; j++) begin : g_stage
    logic [RW-1:0]   rad_i;
    logic [MW-1:0]   rem_i;
    logic [OW-1:0]   root_i;
    logic [MW+1:0]   cand;
    logic [MW+1:0]   trial;
    logic            ge;

    if (j == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign rad_i  = rad_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
    end

    assign cand  = {rem_i, rad_i[RW-1 -: 2]};
    assign trial = {2'b00, root_i, 2'b01};
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      rad_r[j]  <= rad_i << 2;
      rem_r[j]  <= ge ? MW'(cand - trial) : MW'(cand);
      root_r[j] <= {root_i[OW-2:0], ge};
    end
  end

  assign root = root_r[OW-1];

endmodule

// ----- hw/rtl/scr_div.sv -----
module scr_div import scr_pkg::*; #(
  parameter int NUM_W = NNUM_W,
  parameter int DEN_W = DIFF_W,
  parameter int Q_W   = NQ_W
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [DEN_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   lo_r  [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [DEN_W-1:0] rem_i;
    logic [Q_W-1:0]   lo_i;
    logic [Q_W-1:0]   q_i;
    logic [DEN_W-1:0] den_i;
    logic [DEN_W:0]   cand;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_i = DEN_W'(num[NUM_W-1:Q_W]);
      assign lo_i  = num[Q_W-1:0];
      assign q_i   = '0;
      assign den_i = den;
    end else begin : g_next
      assign rem_i = rem_r[j-1];
      assign lo_i  = lo_r[j-1];
      assign q_i   = q_r[j-1];
      assign den_i = den_r[j-1];
    end

    assign cand = {rem_i, lo_i[Q_W-1]};
    assign ge   = cand >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      rem_r[j] <= ge ? DEN_W'(cand - {1'b0, den_i}) : DEN_W'(cand);
      lo_r[j]  <= lo_i << 1;
      q_r[j]   <= {q_i[Q_W-2:0], ge};
      den_r[j] <= den_i;
    end
  end

  assign quo = q_r[Q_W-1];

endmodule

// ----- hw/rtl/sphere_collision_response.sv -----
// The path from start to out_strobe runs through the 33-stage square
// root and the 31-stage normal divider in series.
// Throughput: one word per cycle; busy drops in the cycle after reset release.
// The receiver cannot stall, so the pipeline always advances.
// Synchronous active-low reset clears valid bits and loads config defaults.
module sphere_collision_response import scr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [POS_W-1:0] in_self_pos_x,
  input  logic signed [POS_W-1:0] in_self_pos_y,
  input  logic signed [POS_W-1:0] in_self_pos_z,
  input  logic signed [POS_W-1:0] in_self_vel_x,
  input  logic signed [POS_W-1:0] in_self_vel_y,
  input  logic signed [POS_W-1:0] in_self_vel_z,
  input  logic signed [POS_W-1:0] in_other_pos_x,
  input  logic signed [POS_W-1:0] in_other_pos_y,
  input  logic signed [POS_W-1:0] in_other_pos_z,
  input  logic signed [POS_W-1:0] in_other_vel_x,
  input  logic signed [POS_W-1:0] in_other_vel_y,
  input  logic signed [POS_W-1:0] in_other_vel_z,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic signed [POS_W-1:0] out_new_vel_x,
  output logic signed [POS_W-1:0] out_new_vel_y,
  output logic signed [POS_W-1:0] out_new_vel_z,
  output logic signed [POS_W-1:0] out_new_self_pos_x,
  output logic signed [POS_W-1:0] out_new_self_pos_y,
  output logic signed [POS_W-1:0] out_new_self_pos_z,
  output logic signed [POS_W-1:0] out_new_other_pos_x,
  output logic signed [POS_W-1:0] out_new_other_pos_y,
  output logic signed [POS_W-1:0] out_new_other_pos_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int ST_A    = 1;
  localparam int ST_S    = ST_A + 2;
  localparam int ST_DIST = ST_S + ROOT_W;
  localparam int ST_Q    = ST_DIST + NQ_W;
  localparam int ST_W    = ST_DIST + WQ_W;
  localparam int ST_F    = ST_Q + 1;
  localparam int ST_I    = ST_F + 3;
  localparam int ST_J    = ST_F + 4;
  localparam int ST_K    = ST_F + 5;
  localparam int ST_M    = ST_F + 7;
  localparam int ST_N    = ST_F + 8;

  logic [MASS_W-1:0] self_mass_r, other_mass_r, self_radius_r, other_radius_r;
  logic [ELAS_W-1:0] elas_r;
  logic              rdy_r;
  logic              accept;
  logic [ST_N-1:0]   vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_mass_r    <= RST_MASS;
      other_mass_r   <= RST_MASS;
      self_radius_r  <= RST_RADIUS;
      other_radius_r <= RST_RADIUS;
      elas_r         <= RST_ELAS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SELF_MASS:    self_mass_r    <= cfg_data[MASS_W-1:0];
        REG_OTHER_MASS:   other_mass_r   <= cfg_data[MASS_W-1:0];
        REG_SELF_RADIUS:  self_radius_r  <= cfg_data[MASS_W-1:0];
        REG_OTHER_RADIUS: other_radius_r <= cfg_data[MASS_W-1:0];
        REG_ELASTICITY:   elas_r         <= cfg_data[ELAS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r <= 1'b0;
      vld_r <= '0;
    end else begin
      rdy_r <= 1'b1;
      vld_r <= {vld_r[ST_N-2:0], accept};
    end
  end

  assign busy       = !rdy_r;
  assign accept     = start && rdy_r;
  assign out_strobe = vld_r[ST_N-1];

  vec3_t sp_w, sv_w, op_w, ov_w;
  assign sp_w = {in_self_pos_z, in_self_pos_y, in_self_pos_x};
  assign sv_w = {in_self_vel_z, in_self_vel_y, in_self_vel_x};
  assign op_w = {in_other_pos_z, in_other_pos_y, in_other_pos_x};
  assign ov_w = {in_other_vel_z, in_other_vel_y, in_other_vel_x};

  logic [2:0][DIFF_W-1:0] a_dmag_r, a_vr_r;
  logic [2:0]             a_dneg_r;
  vec3_t                  a_sp_r, a_op_r, a_sv_r;
  logic [RAD_W-1:0]       sq_r [3];
  logic [RAD_W-1:0]       s_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic [DIFF_W-1:0] d;
      d = {sp_w[i][POS_W-1], sp_w[i]} - {op_w[i][POS_W-1], op_w[i]};
      a_dneg_r[i] <= d[DIFF_W-1];
      a_dmag_r[i] <= d[DIFF_W-1] ? DIFF_W'(-d) : d;
      a_vr_r[i]   <= {sv_w[i][POS_W-1], sv_w[i]} - {ov_w[i][POS_W-1], ov_w[i]};
    end
    a_sp_r <= sp_w;
    a_op_r <= op_w;
    a_sv_r <= sv_w;
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= RAD_W'(a_dmag_r[i]) * RAD_W'(a_dmag_r[i]);
    end
    s_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  logic [ROOT_W-1:0] dist_w;

  scr_sqrt #(.RW(RAD_W)) u_sqrt (
    .clk  (clk),
    .rad  (s_r),
    .root (dist_w)
  );

  logic [2:0][DIFF_W-1:0] dmag_s;

  scr_dly #(.W(3*DIFF_W), .D(ST_DIST-ST_A)) u_dly_dmag (
    .clk (clk), .d (a_dmag_r), .q (dmag_s)
  );

  logic [2:0][NQ_W-1:0] q_w;

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    scr_div #(.NUM_W(NNUM_W), .DEN_W(ROOT_W), .Q_W(NQ_W)) u_div (
      .clk (clk),
      .num ({dmag_s[i], {NFRAC_W{1'b0}}}),
      .den (dist_w),
      .quo (q_w[i])
    );
  end

  logic [MSUM_W-1:0] msum;
  logic [WQ_W-1:0]   w_q, w_d, w_use;
  assign msum = MSUM_W'(self_mass_r) + MSUM_W'(other_mass_r);

  scr_div #(.NUM_W(WNUM_W), .DEN_W(MSUM_W), .Q_W(WQ_W)) u_wdiv (
    .clk (clk),
    .num ({other_mass_r, 16'd0}),
    .den (msum),
    .quo (w_q)
  );

  scr_dly #(.W(WQ_W), .D(ST_I-ST_W)) u_dly_w (.clk (clk), .d (w_q), .q (w_d));
  assign w_use = (msum == '0) ? '0 : w_d;

  logic [ROOT_W-1:0]      dist_q;
  logic [2:0]             dneg_q;
  logic [2:0][DIFF_W-1:0] vr_g;
  vec3_t                  sp_k, op_k, sv_k;

  scr_dly #(.W(ROOT_W), .D(NQ_W)) u_dly_dist (.clk (clk), .d (dist_w), .q (dist_q));
  scr_dly #(.W(3), .D(ST_Q-ST_A)) u_dly_dneg (.clk (clk), .d (a_dneg_r), .q (dneg_q));
  scr_dly #(.W(3*DIFF_W), .D(ST_F-ST_A)) u_dly_vr (.clk (clk), .d (a_vr_r), .q (vr_g));
  scr_dly #(.W(9*POS_W), .D(ST_K-ST_A)) u_dly_pv (
    .clk (clk), .d ({a_sv_r, a_op_r, a_sp_r}), .q ({sv_k, op_k, sp_k})
  );

  logic [MSUM_W-1:0]        rsum;
  logic [2:0][NQ_W-1:0]     nmag_r, nmag_j;
  logic [2:0]               nneg_r, nneg_j;
  logic signed [POS_W-1:0]  n_r [3];
  logic [MASS_W-1:0]        h_r, h_j;
  logic                     hit_r, hit_m;

  assign rsum = MSUM_W'(self_radius_r) + MSUM_W'(other_radius_r);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nmag_r[i] <= (dist_q == '0) ? '0 : q_w[i];
      nneg_r[i] <= dneg_q[i] && (dist_q != '0);
      if (dist_q == '0) begin
        n_r[i] <= '0;
      end else if (dneg_q[i]) begin
        n_r[i] <= -$signed(POS_W'(q_w[i]));
      end else begin
        n_r[i] <= $signed(POS_W'(q_w[i]));
      end
    end
    hit_r <= ROOT_W'(rsum) > dist_q;
    h_r   <= (ROOT_W'(rsum) > dist_q) ? MASS_W'((ROOT_W'(rsum) - dist_q) >> 1) : '0;
  end

  scr_dly #(.W(3*NQ_W+3+MASS_W), .D(ST_J-ST_F)) u_dly_n (
    .clk (clk), .d ({nmag_r, nneg_r, h_r}), .q ({nmag_j, nneg_j, h_j})
  );
  scr_dly #(.W(1), .D(ST_M-ST_F)) u_dly_hit (.clk (clk), .d (hit_r), .q (hit_m));

  logic signed [2*DIFF_W-2:0] pv_r [3];
  logic [63:0]                dot_r;
  logic [63:0]                kmag;
  logic [51:0]                t1_r;
  logic                       vneg_r, cneg_r;
  logic [52:0]                t2_r;
  logic [36:0]                c_w;

  assign kmag = dot_r[63] ? -dot_r : dot_r;
  assign c_w  = t2_r[52:16];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pv_r[i] <= $signed(vr_g[i]) * n_r[i];
    end
    dot_r  <= pv_r[0][63:0] + pv_r[1][63:0] + pv_r[2][63:0];
    vneg_r <= dot_r[63];
    t1_r   <= 52'(kmag[63:30]) * 52'(18'(elas_r) + 18'd65536);
    cneg_r <= !vneg_r;
    t2_r   <= 53'(t1_r[51:16]) * 53'(w_use);
  end

  logic [52:0]     ahc_r [3];
  logic [51:0]     alc_r [3];
  logic [61:0]     smp_r [3];
  logic [2:0]      dneg_k_r, nneg_k_r;
  logic [U_W-1:0]  u_r [3];
  vec3_t           ps_l_r, po_l_r, ps_m_r, po_m_r;
  logic [53:0]     um_r [3];
  logic [2:0]      uneg_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ahc_r[i]    <= 53'(nmag_j[i][30:15]) * 53'(c_w);
      alc_r[i]    <= 52'(nmag_j[i][14:0]) * 52'(c_w);
      smp_r[i]    <= 62'(nmag_j[i]) * 62'(h_j);
      dneg_k_r[i] <= nneg_j[i] != cneg_r;
      nneg_k_r[i] <= nneg_j[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic [53:0]            dsum;
      logic [U_W-1:0]         velx, dvx;
      logic [SAT_W-1:0]       s40;
      logic [U_W-1:0]         umag;
      dsum = 54'(ahc_r[i]) + 54'(alc_r[i][51:15]);
      velx = {{(U_W-POS_W){sv_k[i][POS_W-1]}}, sv_k[i]};
      dvx  = {1'b0, dsum[51:15]};
      u_r[i] <= dneg_k_r[i] ? velx - dvx : velx + dvx;
      s40  = nneg_k_r[i] ? -SAT_W'(smp_r[i][61:30]) : SAT_W'(smp_r[i][61:30]);
      ps_l_r[i] <= sat32($signed({{(SAT_W-POS_W){sp_k[i][POS_W-1]}}, sp_k[i]} + s40));
      po_l_r[i] <= sat32($signed({{(SAT_W-POS_W){op_k[i][POS_W-1]}}, op_k[i]} - s40));
      umag = u_r[i][U_W-1] ? -u_r[i] : u_r[i];
      um_r[i]   <= 54'(umag[U_W-2:0]) * 54'(elas_r);
      uneg_r[i] <= u_r[i][U_W-1];
    end
    ps_m_r <= ps_l_r;
    po_m_r <= po_l_r;
  end

  vec3_t nv_r, ns_r, no_r;
  logic  hit_o_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic [SAT_W-1:0] r40;
      r40 = SAT_W'(um_r[i][53:16]);
      nv_r[i] <= sat32($signed(uneg_r[i] ? -r40 : r40));
    end
    ns_r    <= ps_m_r;
    no_r    <= po_m_r;
    hit_o_r <= hit_m;
  end

  assign out_hit             = hit_o_r;
  assign out_new_vel_x       = nv_r[0];
  assign out_new_vel_y       = nv_r[1];
  assign out_new_vel_z       = nv_r[2];
  assign out_new_self_pos_x  = ns_r[0];
  assign out_new_self_pos_y  = ns_r[1];
  assign out_new_self_pos_z  = ns_r[2];
  assign out_new_other_pos_x = no_r[0];
  assign out_new_other_pos_y = no_r[1];
  assign out_new_other_pos_z = no_r[2];

endmodule
